### rtl/core/path_follow_mode_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the path follow mode controller
// Clocked assertions with an active-low reset; ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef PATH_FOLLOW_MODE_CONTROLLER_MACROS_SVH
`define PATH_FOLLOW_MODE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// check a property at every rising edge outside reset
`define PFMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that a condition never holds outside reset
`define PFMC_NEVER(lbl, clk, rst_n, cond, msg) \
    `PFMC_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define PFMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFMC_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/core/pfmc_pkg.sv
// ----------------------------------------------------------------------------
// pfmc_pkg
// Types, codes and reset values shared by the path follow mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pfmc_pkg;

    // motion modes
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'd0,
        MODE_FIXED  = 4'd1,
        MODE_FOLLOW = 4'd2,
        MODE_STEP   = 4'd3,
        MODE_SPIN   = 4'd4,
        MODE_STOP   = 4'd5,
        MODE_REV    = 4'd6,
        MODE_HAZ    = 4'd7,
        MODE_WAIT   = 4'd8
    } mode_t;

    // destination of a stop
    typedef enum logic [1:0] {
        TGT_IDLE   = 2'd0,
        TGT_FIXED  = 2'd1,
        TGT_SPIN   = 2'd2,
        TGT_FOLLOW = 2'd3
    } tgt_t;

    // configuration register indexes
    typedef enum logic [3:0] {
        REG_IDLE_SPEED_MAX   = 4'd0,
        REG_IDLE_TURN_MAX    = 4'd1,
        REG_SPIN_SPEED_MAX   = 4'd2,
        REG_FOLLOW_TURN_MAX  = 4'd3,
        REG_STOP_TIMEOUT     = 4'd4,
        REG_REPLAN_TIMEOUT   = 4'd5,
        REG_REVERSE_DISTANCE = 4'd6,
        REG_REVERSE_TIMEOUT  = 4'd7
    } cfg_idx_t;

    localparam int unsigned CfgDataW = 20;

    // register reset values
    localparam logic [14:0] IdleSpeedRst   = 15'd50;
    localparam logic [14:0] IdleTurnRst    = 15'd100;
    localparam logic [14:0] SpinSpeedRst   = 15'd100;
    localparam logic [14:0] FollowTurnRst  = 15'd200;
    localparam logic [19:0] StopTimeRst    = 20'd2000;
    localparam logic [19:0] ReplanTimeRst  = 20'd3000;
    localparam logic [15:0] RevDistRst     = 16'd300;
    localparam logic [19:0] RevTimeRst     = 20'd5000;

    // one control tick
    typedef struct packed {
        logic        [31:0] stamp_ms;
        logic signed [23:0] pos_x_mm;
        logic signed [23:0] pos_y_mm;
        logic signed [15:0] speed_mm_s;
        logic signed [15:0] turn_mrad_s;
        logic        [3:0]  safety_flags;
        logic        [5:0]  path_flags;
        logic        [3:0]  goal_flags;
    } in_item_t;

    // one result
    typedef struct packed {
        mode_t mode;
        logic  consume_path;
        logic  request_replan;
    } out_item_t;

    // status from the reverse tracker
    typedef struct packed {
        logic        leave;
        logic [31:0] accum_sum;
    } rev_stat_t;

endpackage

`default_nettype wire

### rtl/core/pfmc_rev_track.sv
// ----------------------------------------------------------------------------
// pfmc_rev_track
// Reverse exit test: squared displacement against squared distance, and
// accumulated reverse time (saturating) against the reverse timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module pfmc_rev_track (
    input  wire logic        [31:0] stamp_ms,
    input  wire logic signed [23:0] pos_x_mm,
    input  wire logic signed [23:0] pos_y_mm,
    input  wire logic signed [23:0] entry_x,
    input  wire logic signed [23:0] entry_y,
    input  wire logic        [31:0] accum_ms,
    input  wire logic        [31:0] last_ms,
    input  wire logic        [15:0] distance_mm,
    input  wire logic        [19:0] timeout_ms,
    output pfmc_pkg::rev_stat_t     stat
);

    logic        [31:0] delta_ms;
    logic        [32:0] elapsed;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [49:0] dx_sq;
    logic signed [49:0] dy_sq;
    logic        [48:0] dist_sq;
    logic        [31:0] thr_sq;
    logic               near;
    logic               early;

    // elapsed reverse time, formed wide so it cannot wrap
    assign delta_ms = stamp_ms - last_ms;
    assign elapsed  = {1'b0, accum_ms} + {1'b0, delta_ms};

    // displacement from the entry point
    assign dx    = {pos_x_mm[23], pos_x_mm} - {entry_x[23], entry_x};
    assign dy    = {pos_y_mm[23], pos_y_mm} - {entry_y[23], entry_y};
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign dist_sq = {1'b0, dx_sq[47:0]} + {1'b0, dy_sq[47:0]};
    assign thr_sq  = distance_mm * distance_mm;

    assign near  = dist_sq < {17'd0, thr_sq};
    assign early = elapsed < {13'd0, timeout_ms};

    // leave reverse on distance or time; saturate the accumulated time
    assign stat.leave     = !(near && early);
    assign stat.accum_sum = elapsed[32] ? 32'hFFFF_FFFF : elapsed[31:0];

endmodule

`default_nettype wire

### rtl/core/path_follow_mode_controller.sv
// ----------------------------------------------------------------------------
// path_follow_mode_controller
// Nine-mode motion supervisor: one control tick in, new mode and planner
// strobes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one control tick per transfer (valid/ready, in_item_t payload).
//   out_*  : one result per tick (valid/ready, out_item_t payload), in order.
//   cfg_*  : register writes (index, 20-bit data); always ready, indexes of
//            eight and above are dropped. Write only while the block is idle.
// Path: a tick is captured in the input register, evaluated against the
//   held mode and lands in the output register.
// Throughput: one tick per cycle while the receiver takes each result; the
//   held mode and bookkeeping update in the same cycle that a result is
//   registered, so the next tick sees them. The longest path is the two
//   displacement squarings and their compare.
// Reset: mode idle, stop target idle, all time and position marks zero,
//   registers at their reset values, both pipeline stages empty.
// Stall: with the output held, the input register still takes one more
//   tick; after that in_ready drops until the receiver takes the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "path_follow_mode_controller_macros.svh"

module path_follow_mode_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pfmc_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pfmc_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [3:0]           cfg_index,
    input  wire logic [pfmc_pkg::CfgDataW-1:0] cfg_data
);

    // configuration registers
    logic [14:0] idle_speed_reg;
    logic [14:0] idle_turn_reg;
    logic [14:0] spin_speed_reg;
    logic [14:0] follow_turn_reg;
    logic [19:0] stop_time_reg;
    logic [19:0] replan_time_reg;
    logic [15:0] rev_dist_reg;
    logic [19:0] rev_time_reg;

    // pipeline
    logic                 s1_valid_reg;
    pfmc_pkg::in_item_t   s1_item_reg;
    logic                 out_valid_reg;
    pfmc_pkg::out_item_t  out_item_reg;
    logic                 advance;

    // held state
    pfmc_pkg::mode_t      mode_reg, mode_next;
    pfmc_pkg::tgt_t       tgt_reg, tgt_next;
    logic                 rar_reg, rar_next;
    logic [31:0]          stop_start_reg, stop_start_next;
    logic [31:0]          wait_start_reg, wait_start_next;
    logic signed [23:0]   entry_x_reg, entry_x_next;
    logic signed [23:0]   entry_y_reg, entry_y_next;
    logic [31:0]          accum_reg, accum_next;
    logic [31:0]          last_reg, last_next;
    logic                 cons;
    logic                 repl;

    // decoded tick
    logic        hazard, rec_safe, stuck, blocked;
    logic        new_path, has_path, replan_req, replan_fail, goal, no_prog;
    logic        spin_req, spin_hi, fixed_goal, step_act;
    logic [16:0] spd_mag, turn_mag;
    logic        settled;
    logic        stop_late;
    logic        wait_late;
    logic        spin_keep;
    pfmc_pkg::mode_t route_mode;
    pfmc_pkg::mode_t give_up_mode;
    pfmc_pkg::rev_stat_t rev_stat;

    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? (17'd0 - ext) : ext;
    endfunction

    // ------------------------------------------------------------------
    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_speed_reg  <= pfmc_pkg::IdleSpeedRst;
            idle_turn_reg   <= pfmc_pkg::IdleTurnRst;
            spin_speed_reg  <= pfmc_pkg::SpinSpeedRst;
            follow_turn_reg <= pfmc_pkg::FollowTurnRst;
            stop_time_reg   <= pfmc_pkg::StopTimeRst;
            replan_time_reg <= pfmc_pkg::ReplanTimeRst;
            rev_dist_reg    <= pfmc_pkg::RevDistRst;
            rev_time_reg    <= pfmc_pkg::RevTimeRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pfmc_pkg::cfg_idx_t'(cfg_index))
                pfmc_pkg::REG_IDLE_SPEED_MAX:   idle_speed_reg  <= cfg_data[14:0];
                pfmc_pkg::REG_IDLE_TURN_MAX:    idle_turn_reg   <= cfg_data[14:0];
                pfmc_pkg::REG_SPIN_SPEED_MAX:   spin_speed_reg  <= cfg_data[14:0];
                pfmc_pkg::REG_FOLLOW_TURN_MAX:  follow_turn_reg <= cfg_data[14:0];
                pfmc_pkg::REG_STOP_TIMEOUT:     stop_time_reg   <= cfg_data;
                pfmc_pkg::REG_REPLAN_TIMEOUT:   replan_time_reg <= cfg_data;
                pfmc_pkg::REG_REVERSE_DISTANCE: rev_dist_reg    <= cfg_data[15:0];
                pfmc_pkg::REG_REVERSE_TIMEOUT:  rev_time_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline handshake: advance when the output register is free
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // capture the tick and the result
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg.mode           <= mode_next;
            out_item_reg.consume_path   <= cons;
            out_item_reg.request_replan <= repl;
        end
    end

    // ------------------------------------------------------------------
    // decode the tick
    assign hazard      = s1_item_reg.safety_flags[0];
    assign rec_safe    = s1_item_reg.safety_flags[1];
    assign stuck       = s1_item_reg.safety_flags[2];
    assign blocked     = s1_item_reg.safety_flags[3];
    assign new_path    = s1_item_reg.path_flags[0];
    assign has_path    = s1_item_reg.path_flags[1];
    assign replan_req  = s1_item_reg.path_flags[2];
    assign replan_fail = s1_item_reg.path_flags[3];
    assign goal        = s1_item_reg.path_flags[4];
    assign no_prog     = s1_item_reg.path_flags[5];
    assign spin_req    = s1_item_reg.goal_flags[0];
    assign spin_hi     = s1_item_reg.goal_flags[1];
    assign fixed_goal  = s1_item_reg.goal_flags[2];
    assign step_act    = s1_item_reg.goal_flags[3];

    assign spd_mag  = abs17(s1_item_reg.speed_mm_s);
    assign turn_mag = abs17(s1_item_reg.turn_mrad_s);

    // settling test for the stop destination
    always_comb
    begin
        case (tgt_reg)
            pfmc_pkg::TGT_SPIN:
                settled = (spd_mag < {2'b0, spin_speed_reg})
                       && (turn_mag < {2'b0, idle_turn_reg});
            pfmc_pkg::TGT_FOLLOW:
                settled = (spd_mag < {2'b0, idle_speed_reg})
                       && (turn_mag < {2'b0, follow_turn_reg});
            default:
                settled = (spd_mag < {2'b0, idle_speed_reg})
                       && (turn_mag < {2'b0, idle_turn_reg});
        endcase
    end

    assign stop_late = (s1_item_reg.stamp_ms - stop_start_reg) > {12'd0, stop_time_reg};
    assign wait_late = (s1_item_reg.stamp_ms - wait_start_reg) > {12'd0, replan_time_reg};
    assign spin_keep = spin_req && (spin_hi || (!has_path && !fixed_goal));

    // where to go once a maneuver is over; idle also drops the path
    assign route_mode = spin_keep  ? pfmc_pkg::MODE_SPIN   :
                        has_path   ? pfmc_pkg::MODE_FOLLOW :
                        fixed_goal ? pfmc_pkg::MODE_FIXED  : pfmc_pkg::MODE_IDLE;
    assign give_up_mode = (spin_req && (spin_hi || !fixed_goal)) ?
                          pfmc_pkg::MODE_SPIN : pfmc_pkg::MODE_IDLE;

    pfmc_rev_track u_rev_track (
        .stamp_ms    (s1_item_reg.stamp_ms),
        .pos_x_mm    (s1_item_reg.pos_x_mm),
        .pos_y_mm    (s1_item_reg.pos_y_mm),
        .entry_x     (entry_x_reg),
        .entry_y     (entry_y_reg),
        .accum_ms    (accum_reg),
        .last_ms     (last_reg),
        .distance_mm (rev_dist_reg),
        .timeout_ms  (rev_time_reg),
        .stat        (rev_stat)
    );

    // ------------------------------------------------------------------
    // next mode, bookkeeping and strobes
    always_comb
    begin
        mode_next       = mode_reg;
        tgt_next        = tgt_reg;
        rar_next        = rar_reg;
        stop_start_next = stop_start_reg;
        wait_start_next = wait_start_reg;
        entry_x_next    = entry_x_reg;
        entry_y_next    = entry_y_reg;
        accum_next      = accum_reg;
        last_next       = last_reg;
        cons            = 1'b0;
        repl            = 1'b0;

        case (mode_reg)
            pfmc_pkg::MODE_IDLE:
            begin
                if (hazard)
                    mode_next = pfmc_pkg::MODE_HAZ;
                else if (new_path)
                    mode_next = pfmc_pkg::MODE_FOLLOW;
                else if (spin_req)
                    mode_next = pfmc_pkg::MODE_SPIN;
            end
            pfmc_pkg::MODE_FIXED:
            begin
                if (stuck)
                begin
                    mode_next = pfmc_pkg::MODE_REV;
                    rar_next  = 1'b1;
                end
                else if (spin_req && spin_hi)
                begin
                    mode_next = pfmc_pkg::MODE_STOP;
                    tgt_next  = pfmc_pkg::TGT_SPIN;
                end
                else if (new_path)
                    mode_next = pfmc_pkg::MODE_FOLLOW;
            end
            pfmc_pkg::MODE_FOLLOW:
            begin
                if (step_act)
                    mode_next = pfmc_pkg::MODE_STEP;
                else if (replan_req)
                    mode_next = pfmc_pkg::MODE_WAIT;
                else if (no_prog)
                begin
                    if (hazard)
                    begin
                        mode_next = pfmc_pkg::MODE_HAZ;
                        rar_next  = 1'b1;
                    end
                    else
                        mode_next = pfmc_pkg::MODE_WAIT;
                end
                else if (!has_path)
                begin
                    mode_next = pfmc_pkg::MODE_STOP;
                    if (spin_req && (spin_hi || !fixed_goal))
                        tgt_next = pfmc_pkg::TGT_SPIN;
                    else
                        tgt_next = fixed_goal ? pfmc_pkg::TGT_FIXED : pfmc_pkg::TGT_IDLE;
                end
                else if (stuck)
                begin
                    mode_next = pfmc_pkg::MODE_REV;
                    rar_next  = 1'b1;
                end
                else if (spin_req && spin_hi)
                begin
                    mode_next = pfmc_pkg::MODE_STOP;
                    tgt_next  = pfmc_pkg::TGT_SPIN;
                end
                else if (goal)
                begin
                    mode_next = pfmc_pkg::MODE_STOP;
                    tgt_next  = fixed_goal ? pfmc_pkg::TGT_FIXED : pfmc_pkg::TGT_IDLE;
                end
            end
            pfmc_pkg::MODE_STEP:
            begin
                if (no_prog)
                begin
                    if (hazard)
                    begin
                        mode_next = pfmc_pkg::MODE_HAZ;
                        rar_next  = 1'b1;
                    end
                    else
                        mode_next = pfmc_pkg::MODE_WAIT;
                end
                else if (stuck)
                begin
                    mode_next = pfmc_pkg::MODE_REV;
                    rar_next  = 1'b0;
                end
                else if (step_act)
                    mode_next = pfmc_pkg::MODE_STEP;
                else if (replan_req)
                    mode_next = pfmc_pkg::MODE_WAIT;
                else
                    mode_next = pfmc_pkg::MODE_FOLLOW;
            end
            pfmc_pkg::MODE_SPIN:
            begin
                if (hazard)
                    mode_next = pfmc_pkg::MODE_HAZ;
                else if (!spin_keep)
                begin
                    mode_next = pfmc_pkg::MODE_STOP;
                    tgt_next  = has_path   ? pfmc_pkg::TGT_FOLLOW :
                                fixed_goal ? pfmc_pkg::TGT_FIXED  : pfmc_pkg::TGT_IDLE;
                end
            end
            pfmc_pkg::MODE_STOP:
            begin
                if (tgt_reg != pfmc_pkg::TGT_FOLLOW && new_path)
                    mode_next = pfmc_pkg::MODE_FOLLOW;
                else if (settled || stop_late)
                begin
                    case (tgt_reg)
                        pfmc_pkg::TGT_IDLE:  mode_next = pfmc_pkg::MODE_IDLE;
                        pfmc_pkg::TGT_FIXED: mode_next = pfmc_pkg::MODE_FIXED;
                        pfmc_pkg::TGT_SPIN:  mode_next = pfmc_pkg::MODE_SPIN;
                        default:             mode_next = pfmc_pkg::MODE_FOLLOW;
                    endcase
                end
            end
            pfmc_pkg::MODE_REV:
            begin
                if (blocked)
                begin
                    accum_next = rev_stat.accum_sum;
                    last_next  = s1_item_reg.stamp_ms;
                end
                else if (rev_stat.leave)
                begin
                    accum_next = 32'd0;
                    if (hazard)
                        mode_next = pfmc_pkg::MODE_HAZ;
                    else if (rar_reg)
                    begin
                        rar_next  = 1'b0;
                        mode_next = pfmc_pkg::MODE_WAIT;
                    end
                    else
                        mode_next = route_mode;
                end
            end
            pfmc_pkg::MODE_HAZ:
            begin
                if (stuck)
                begin
                    mode_next = pfmc_pkg::MODE_REV;
                    rar_next  = 1'b0;
                end
                else if (rec_safe)
                begin
                    if (rar_reg)
                    begin
                        rar_next  = 1'b0;
                        mode_next = pfmc_pkg::MODE_WAIT;
                    end
                    else
                        mode_next = route_mode;
                end
            end
            pfmc_pkg::MODE_WAIT:
            begin
                if (new_path)
                    mode_next = pfmc_pkg::MODE_FOLLOW;
                else if (replan_fail || wait_late)
                    mode_next = give_up_mode;
                else
                begin
                    cons = 1'b1;
                    repl = 1'b1;
                end
            end
            default: ;
        endcase

        // entry actions on a change of mode
        if (mode_next != mode_reg)
        begin
            case (mode_next)
                pfmc_pkg::MODE_STOP:
                    stop_start_next = s1_item_reg.stamp_ms;
                pfmc_pkg::MODE_WAIT:
                begin
                    wait_start_next = s1_item_reg.stamp_ms;
                    cons = 1'b1;
                    repl = 1'b1;
                end
                pfmc_pkg::MODE_REV:
                begin
                    entry_x_next = s1_item_reg.pos_x_mm;
                    entry_y_next = s1_item_reg.pos_y_mm;
                    last_next    = s1_item_reg.stamp_ms;
                    accum_next   = 32'd0;
                end
                pfmc_pkg::MODE_IDLE:
                    cons = 1'b1;
                pfmc_pkg::MODE_FIXED:
                    cons = (mode_reg == pfmc_pkg::MODE_STOP);
                default: ;
            endcase
        end
    end

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= pfmc_pkg::MODE_IDLE;
        else if (advance)
            mode_reg <= mode_next;
    end

    // bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg        <= pfmc_pkg::TGT_IDLE;
            rar_reg        <= 1'b0;
            stop_start_reg <= 32'd0;
            wait_start_reg <= 32'd0;
            entry_x_reg    <= 24'sd0;
            entry_y_reg    <= 24'sd0;
            accum_reg      <= 32'd0;
            last_reg       <= 32'd0;
        end
        else if (advance)
        begin
            tgt_reg        <= tgt_next;
            rar_reg        <= rar_next;
            stop_start_reg <= stop_start_next;
            wait_start_reg <= wait_start_next;
            entry_x_reg    <= entry_x_next;
            entry_y_reg    <= entry_y_next;
            accum_reg      <= accum_next;
            last_reg       <= last_next;
        end
    end

    // ------------------------------------------------------------------
    // checks
    `PFMC_ASSERT(a_mode_matches, clk, rst_n, out_valid |-> out_data.mode == mode_reg, "result mode differs from held mode")
    `PFMC_ASSERT(a_replan_consumes, clk, rst_n, (out_valid && out_data.request_replan) |-> out_data.consume_path, "replan request without path drop")
    `PFMC_ASSERT(a_replan_in_wait, clk, rst_n, (out_valid && out_data.request_replan) |-> out_data.mode == pfmc_pkg::MODE_WAIT, "replan request outside wait mode")
    `PFMC_ASSERT(a_rev_entry_clear, clk, rst_n, (mode_reg == pfmc_pkg::MODE_REV && $past(mode_reg) != pfmc_pkg::MODE_REV) |-> accum_reg == 32'd0, "reverse entered with stale time")
    `PFMC_NEVER(a_stall_needs_item, clk, rst_n, !in_ready && !s1_valid_reg, "input stalled with empty stage")

endmodule

`default_nettype wire
